// ===== rtl/skt_pkg.sv =====
// ----------------------------------------------------------------------------
// skt_pkg
// Shared types and constants for the sorted key toggle table.
// ----------------------------------------------------------------------------
`default_nettype none

package skt_pkg;

  localparam int TABLE_DEPTH   = 64;
  localparam int KEY_W         = 32;
  localparam int SEC_W         = 16;
  localparam int PAGE_W        = 16;
  localparam int POS_W         = 8;
  localparam int ENTRY_COUNT_W = 7;
  localparam int IDX_W         = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W         = $clog2(TABLE_DEPTH + 1);
  localparam int CMP_W         = POS_W + 1;
  localparam int GROUPS        = (TABLE_DEPTH + 7) / 8;

  localparam logic [1:0] CMD_TOGGLE    = 2'd0;
  localparam logic [1:0] CMD_QUERY     = 2'd1;
  localparam logic [1:0] CMD_REMOVE_AT = 2'd2;

  localparam logic [1:0] OUT_REMOVED  = 2'd0;
  localparam logic [1:0] OUT_ADDED    = 2'd1;
  localparam logic [1:0] OUT_FULL     = 2'd2;
  localparam logic [1:0] OUT_NOCHANGE = 2'd3;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [SEC_W-1:0]  section_number;
    logic [PAGE_W-1:0] page_in_section;
    logic [POS_W-1:0]  entry_position;
  } req_t;

  typedef struct packed {
    logic [1:0]               outcome;
    logic                     key_found;
    logic [ENTRY_COUNT_W-1:0] entry_count;
  } rsp_t;

  typedef enum logic [1:0] {
    OP_HOLD      = 2'd0,
    OP_INSERT    = 2'd1,
    OP_DEL_MATCH = 2'd2,
    OP_DEL_POS   = 2'd3
  } cell_op_t;

  typedef struct packed {
    cell_op_t          op;
    logic [KEY_W-1:0]  key;
    logic [POS_W-1:0]  pos;
    logic [CNT_W-1:0]  count;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/skt_cell.sv =====
// ----------------------------------------------------------------------------
// skt_cell
// One slot of the sorted key row: holds a key, registers its compare flags
// against the broadcast key, and shifts toward either neighbor on update.
// ----------------------------------------------------------------------------
`default_nettype none

module skt_cell
  import skt_pkg::*;
(
  input  wire logic             clk,
  input  wire logic [IDX_W-1:0] idx,
  input  wire cell_ctrl_t       ctrl,
  input  wire logic [KEY_W-1:0] left_key,
  input  wire logic [KEY_W-1:0] right_key,
  input  wire logic             left_gt,
  output logic      [KEY_W-1:0] key,
  output logic                  eq,
  output logic                  gt
);

  logic occupied;
  logic at_end;

  assign occupied = CNT_W'(idx) < ctrl.count;
  assign at_end   = CNT_W'(idx) == ctrl.count;

  always_ff @(posedge clk) begin
    eq <= occupied && (key == ctrl.key);
    gt <= occupied && (key > ctrl.key);
  end

  always_ff @(posedge clk) begin
    case (ctrl.op)
      OP_INSERT: begin
        if (gt || at_end) begin
          key <= left_gt ? left_key : ctrl.key;
        end
      end
      OP_DEL_MATCH: begin
        if (eq || gt) begin
          key <= right_key;
        end
      end
      OP_DEL_POS: begin
        if (POS_W'(idx) >= ctrl.pos) begin
          key <= right_key;
        end
      end
      default: begin
        key <= key;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/sorted_key_toggle_table.sv =====
// ----------------------------------------------------------------------------
// sorted_key_toggle_table
// Bounded sorted set of (section, page) keys held in a row of cells, with
// toggle, query and remove-at commands; one result per command.
// ----------------------------------------------------------------------------
//   channel   dir  handshake             payload
//   req       in   req_valid/req_stall   req_t  (cmd, key, position)
//   rsp       out  rsp_valid/rsp_stall   rsp_t  (outcome, found, count)
//
// Each command goes through transfer, cell compare, registered OR tree
// over the match flags, then commit into the cell row and the result register.
// A new command is taken while the previous result still waits in rsp.
// A stalled rsp holds the commit step until the result register frees.
// Reset clears the count and control only; the cells need no clearing.
`default_nettype none

module sorted_key_toggle_table
  import skt_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic req_valid,
  output logic      req_stall,
  input  wire req_t req,
  output logic      rsp_valid,
  input  wire logic rsp_stall,
  output rsp_t      rsp
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_CMP  = 4'b0010,
    ST_RED  = 4'b0100,
    ST_UPD  = 4'b1000
  } state_t;

  state_t            state;
  state_t            state_next;
  logic [1:0]        cmd;
  logic [KEY_W-1:0]  key;
  logic [POS_W-1:0]  pos;
  logic [CNT_W-1:0]  count;
  logic [GROUPS-1:0] grp_or;

  logic [KEY_W-1:0]       key_vec [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] eq_vec;
  logic [TABLE_DEPTH-1:0] gt_vec;
  logic [GROUPS*8-1:0]    eq_pad;

  cell_ctrl_t ctrl;
  cell_op_t   op;
  logic [1:0] outcome;
  logic       found;
  logic       hit;
  logic       commit;
  logic [CNT_W-1:0] count_next;

  assign req_stall = (state != ST_IDLE);
  assign commit    = (state == ST_UPD) && (!rsp_valid || !rsp_stall);
  assign hit       = |grp_or;
  assign eq_pad    = (GROUPS*8)'(eq_vec);

  always_comb begin
    op         = OP_HOLD;
    outcome    = OUT_NOCHANGE;
    found      = 1'b0;
    count_next = count;
    case (cmd)
      CMD_TOGGLE: begin
        if (hit) begin
          op         = OP_DEL_MATCH;
          outcome    = OUT_REMOVED;
          found      = 1'b1;
          count_next = count - CNT_W'(1);
        end else if (count >= CNT_W'(TABLE_DEPTH)) begin
          outcome = OUT_FULL;
        end else begin
          op         = OP_INSERT;
          outcome    = OUT_ADDED;
          count_next = count + CNT_W'(1);
        end
      end
      CMD_QUERY: begin
        found = hit;
      end
      CMD_REMOVE_AT: begin
        if (CMP_W'(pos) < CMP_W'(count)) begin
          op         = OP_DEL_POS;
          outcome    = OUT_REMOVED;
          count_next = count - CNT_W'(1);
        end
      end
      default: begin
        op = OP_HOLD;
      end
    endcase
  end

  always_comb begin
    ctrl.op    = commit ? op : OP_HOLD;
    ctrl.key   = key;
    ctrl.pos   = pos;
    ctrl.count = count;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (req_valid) state_next = ST_CMP;
      ST_CMP:  state_next = ST_RED;
      ST_RED:  state_next = ST_UPD;
      ST_UPD:  if (commit) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (commit) begin
        count     <= count_next;
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && req_valid) begin
      cmd <= req.cmd;
      key <= {req.section_number, req.page_in_section};
      pos <= req.entry_position;
    end
    for (int g = 0; g < GROUPS; g++) begin
      grp_or[g] <= |eq_pad[g*8 +: 8];
    end
    if (commit) begin
      rsp.outcome     <= outcome;
      rsp.key_found   <= found;
      rsp.entry_count <= ENTRY_COUNT_W'(count_next);
    end
  end

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    logic [KEY_W-1:0] left_key;
    logic [KEY_W-1:0] right_key;
    logic             left_gt;

    if (i == 0) begin : g_first
      assign left_key = '0;
      assign left_gt  = 1'b0;
    end else begin : g_mid
      assign left_key = key_vec[i-1];
      assign left_gt  = gt_vec[i-1];
    end

    if (i == TABLE_DEPTH - 1) begin : g_last
      assign right_key = key_vec[i];
    end else begin : g_inner
      assign right_key = key_vec[i+1];
    end

    skt_cell u_cell (
      .clk       (clk),
      .idx       (IDX_W'(i)),
      .ctrl      (ctrl),
      .left_key  (left_key),
      .right_key (right_key),
      .left_gt   (left_gt),
      .key       (key_vec[i]),
      .eq        (eq_vec[i]),
      .gt        (gt_vec[i])
    );
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(TABLE_DEPTH))
    else $error("entry count above table depth");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    commit && op == OP_INSERT |=> count == $past(count) + CNT_W'(1))
    else $error("insert did not grow the count");

  a_rsp_after_commit: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state) == ST_UPD)
    else $error("result raised outside commit step");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.outcome == OUT_FULL |->
      rsp.entry_count == ENTRY_COUNT_W'(TABLE_DEPTH))
    else $error("full refusal with room left");

  a_added_not_found: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.outcome == OUT_ADDED |-> !rsp.key_found)
    else $error("key added although present");

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for sorted_key_toggle_table. A directed sequence covers
// the key extremes, every command, remove-at bounds and the unused command
// code. It is followed by random phases that fill the table past its depth,
// drain it and mix commands. A tracker keeps the sorted key set, predicts
// each result and compares it field by field. Random bursts on the request
// side and random stall patterns on the response side vary the timing.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  import skt_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int unsigned RANDOM_ITEMS = 1350;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned SETTLE_CYCLES = 20;

  typedef enum int {PH_FILL, PH_DRAIN, PH_MIXED} phase_e;

  class toggle_table_tracker;
    logic [KEY_W-1:0] keys[$];
    rsp_t pending[$];
    int mismatches = 0;

    function void note_command(req_t r);
      logic [KEY_W-1:0] key;
      int at;
      int p;
      rsp_t e;
      key = {r.section_number, r.page_in_section};
      at = -1;
      foreach (keys[i]) if (keys[i] == key) at = i;
      e.outcome = OUT_NOCHANGE;
      e.key_found = 1'b0;
      case (r.cmd)
        CMD_TOGGLE: begin
          if (at >= 0) begin
            keys.delete(at);
            e.outcome = OUT_REMOVED;
            e.key_found = 1'b1;
          end else if (keys.size() >= TABLE_DEPTH) begin
            e.outcome = OUT_FULL;
          end else begin
            p = 0;
            while (p < keys.size() && keys[p] < key) p++;
            keys.insert(p, key);
            e.outcome = OUT_ADDED;
          end
        end
        CMD_QUERY: e.key_found = (at >= 0);
        CMD_REMOVE_AT: begin
          if (int'(r.entry_position) < keys.size()) begin
            keys.delete(int'(r.entry_position));
            e.outcome = OUT_REMOVED;
          end
        end
        default: ;
      endcase
      e.entry_count = ENTRY_COUNT_W'(keys.size());
      pending.insert(pending.size(), e);
    endfunction

    function void check_response(rsp_t got);
      rsp_t e;
      if (pending.size() == 0) begin
        $error("rsp transfer with no result pending: %h", got);
        mismatches++;
        return;
      end
      e = pending.pop_front();
      if (got.outcome !== e.outcome) begin
        $error("outcome: expected %0d, got %0d", e.outcome, got.outcome);
        mismatches++;
      end
      if (got.key_found !== e.key_found) begin
        $error("key_found: expected %0d, got %0d", e.key_found, got.key_found);
        mismatches++;
      end
      if (got.entry_count !== e.entry_count) begin
        $error("entry_count: expected %0d, got %0d", e.entry_count, got.entry_count);
        mismatches++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  toggle_table_tracker sb = new();
  int unsigned cycle_count = 0;
  int unsigned stall_mode = 0;
  int unsigned stall_left = 0;

  sorted_key_toggle_table u_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && req_valid && !req_stall) sb.note_command(req);
    if (!rst && rsp_valid && !rsp_stall) sb.check_response(rsp);
  end

  // receiver stall patterns: none, light random, heavy random, periodic
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(20, 200);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: rsp_stall <= 1'b0;
      1: rsp_stall <= ($urandom_range(0, 3) == 0);
      2: rsp_stall <= ($urandom_range(0, 9) < 8);
      default: rsp_stall <= (cycle_count[2:0] < 3'd3);
    endcase
  end

  task automatic send(input req_t item);
    req <= item;
    req_valid <= 1'b1;
    do @(posedge clk); while (req_stall);
  endtask

  task automatic idle_for(input int unsigned n);
    req_valid <= 1'b0;
    req <= req_t'({$urandom, $urandom});
    repeat (n) @(posedge clk);
  endtask

  task automatic wait_for_results();
    req_valid <= 1'b0;
    do @(posedge clk); while (sb.pending.size() != 0);
  endtask

  function automatic req_t make_req(logic [1:0] cmd, logic [15:0] sec, logic [15:0] pg,
                                    logic [7:0] pos);
    req_t r;
    r.cmd = cmd;
    r.section_number = sec;
    r.page_in_section = pg;
    r.entry_position = pos;
    return r;
  endfunction

  function automatic req_t pick_item(phase_e ph);
    req_t r;
    int unsigned roll;
    int n;
    logic [KEY_W-1:0] key;
    r = req_t'({$urandom, $urandom});
    n = sb.keys.size();
    roll = $urandom_range(0, 99);
    case (ph)
      PH_FILL: r.cmd = (roll < 85) ? CMD_TOGGLE : (roll < 95) ? CMD_QUERY : CMD_REMOVE_AT;
      PH_DRAIN: r.cmd = (roll < 45) ? CMD_TOGGLE : (roll < 60) ? CMD_QUERY :
                        (roll < 95) ? CMD_REMOVE_AT : CMD_UNUSED;
      default: r.cmd = (roll < 40) ? CMD_TOGGLE : (roll < 65) ? CMD_QUERY :
                       (roll < 90) ? CMD_REMOVE_AT : CMD_UNUSED;
    endcase
    if ($urandom_range(0, 2) == 0) r.section_number = 16'($urandom_range(0, 3));
    if (n > 0 && $urandom_range(0, 99) < ((ph == PH_FILL) ? 15 : 60)) begin
      key = sb.keys[$urandom_range(0, n - 1)];
      r.section_number = key[31:16];
      r.page_in_section = key[15:0];
    end
    if (r.cmd == CMD_REMOVE_AT && n > 0 && $urandom_range(0, 3) != 0)
      r.entry_position = 8'($urandom_range(0, n - 1));
    return r;
  endfunction

  initial begin
    int unsigned sent;
    int unsigned burst;
    int unsigned phase_len;
    phase_e ph;

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send(make_req(CMD_QUERY, 16'h0000, 16'h0000, 8'h00));
    send(make_req(CMD_REMOVE_AT, 16'h1234, 16'h5678, 8'h00));
    send(make_req(CMD_TOGGLE, 16'h0000, 16'h0000, 8'hff));
    send(make_req(CMD_TOGGLE, 16'hffff, 16'hffff, 8'h00));
    send(make_req(CMD_TOGGLE, 16'h0000, 16'hffff, 8'h55));
    send(make_req(CMD_TOGGLE, 16'hffff, 16'h0000, 8'haa));
    send(make_req(CMD_TOGGLE, 16'h0001, 16'h0000, 8'h00));
    send(make_req(CMD_QUERY, 16'hffff, 16'hffff, 8'h00));
    send(make_req(CMD_QUERY, 16'h0000, 16'h0001, 8'h00));
    send(make_req(CMD_TOGGLE, 16'h0000, 16'hffff, 8'h00));
    send(make_req(CMD_REMOVE_AT, 16'h0000, 16'h0000, 8'hff));
    send(make_req(CMD_REMOVE_AT, 16'h0000, 16'h0000, 8'h04));
    send(make_req(CMD_REMOVE_AT, 16'h0000, 16'h0000, 8'h03));
    send(make_req(CMD_REMOVE_AT, 16'hffff, 16'hffff, 8'h00));
    send(make_req(CMD_UNUSED, 16'hffff, 16'hffff, 8'hff));
    send(make_req(CMD_UNUSED, 16'h0000, 16'h0000, 8'h00));
    send(make_req(CMD_QUERY, 16'h0000, 16'h0000, 8'h00));
    send(make_req(CMD_TOGGLE, 16'h0001, 16'h0000, 8'h00));
    send(make_req(CMD_TOGGLE, 16'h8000, 16'h8000, 8'h80));
    send(make_req(CMD_TOGGLE, 16'h7fff, 16'h7fff, 8'h7f));
    wait_for_results();

    sent = 0;
    ph = PH_FILL;
    phase_len = 130;
    while (sent < RANDOM_ITEMS) begin
      for (int unsigned i = 0; i < phase_len && sent < RANDOM_ITEMS; i += burst) begin
        burst = $urandom_range(1, 24);
        for (int unsigned j = 0; j < burst; j++) send(pick_item(ph));
        sent += burst;
        if ($urandom_range(0, 2) != 0) idle_for($urandom_range(1, 8));
      end
      if ($urandom_range(0, 2) == 0 || ph == PH_FILL) wait_for_results();
      ph = phase_e'($urandom_range(0, 2));
      phase_len = $urandom_range(40, 160);
    end

    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

`default_nettype wire
